>>> src/hsha_pkg.sv
// Shared constants, types and SHA-256 helper functions for the HMAC-SHA256 engine.
`default_nettype none
package hsha_pkg;

  localparam int BLOCK_BYTES_DEF = 64;
  localparam int KEY_WORDS       = 8;
  localparam int CFG_IDX_W       = 4;
  localparam logic [7:0] IPAD    = 8'h36;
  localparam logic [7:0] OPAD    = 8'h5c;
  // outer message is one key block plus a 32-byte inner digest
  localparam logic [63:0] OUTER_BITS = 64'd768;

  localparam logic [31:0] RND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // byte source for the block buffer write port
  typedef enum logic [1:0] {
    WR_DATA = 2'd0,
    WR_MARK = 2'd1,
    WR_ZERO = 2'd2,
    WR_LEN  = 2'd3
  } wr_sel_t;

  typedef struct packed {
    logic    cap_byte;
    logic    load_key;
    logic    pad_outer;
    logic    start_comp;
    logic    wr_byte;
    wr_sel_t wr_sel;
    logic    cnt_init;
    logic    cnt_add;
    logic    save_dig;
    logic    load_dig;
    logic    len_outer;
  } dp_cmd_t;

  typedef struct packed {
    logic       busy;
    logic [5:0] fill;
  } dp_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage
`default_nettype wire

>>> src/hmac_sha256_engine_core.sv
// Top level of the HMAC-SHA256 engine: stream ports, configuration port, controller and datapath.
//
//  channel   dir  handshake           payload
//  s_axis    in   tvalid/tready       tdata=data_byte, tuser=has_byte, tlast=last_byte
//  m_axis    out  tvalid/tready       tdata=digest_word, tuser=word_index, tlast=last_word
//  cfg       in   cfg_we              cfg_index, cfg_data (key_word_0..7)
//
// A byte that completes a 64-byte block also starts a compression
// (64 rounds on one shared round unit, a fold into the hash state and a hand-back).
// A message's first item adds a key-block compression; the last item adds padding
// (one byte per cycle while no compression runs), three to four further compressions and the four outputs.
// Synchronous active-high reset clears the controller, fill count and key registers.
// The input is held off while a message is finishing or digest words wait on m_axis.
`default_nettype none
module hmac_sha256_engine_core
  import hsha_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,  // data_byte[7:0]
  input  wire logic                 s_axis_tuser,  // has_byte
  input  wire logic                 s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [63:0]               m_axis_tdata,  // digest_word[63:0]
  output logic [1:0]                m_axis_tuser,  // word_index[1:0]
  output logic                      m_axis_tlast,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [1:0] word_sel;

  hsha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (s_axis_tvalid && s_axis_tready),
    .has_byte  (s_axis_tuser),
    .last_byte (s_axis_tlast),
    .out_fire  (m_axis_tvalid && m_axis_tready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .word_sel  (word_sel)
  );

  hsha_dp #(.BLOCK_BYTES(BLOCK_BYTES)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .data_byte   (s_axis_tdata),
    .word_sel    (word_sel),
    .stat        (stat),
    .digest_word (m_axis_tdata)
  );

  assign m_axis_tuser = word_sel;
  assign m_axis_tlast = (word_sel == 2'd3);

endmodule
`default_nettype wire

>>> src/hsha_dp.sv
// Datapath: key registers, block buffer, message schedule, round unit and hash state.
`default_nettype none
module hsha_dp
  import hsha_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data,
  input  wire dp_cmd_t              cmd,
  input  wire logic [7:0]           data_byte,
  input  wire logic [1:0]           word_sel,
  output dp_stat_t                  stat,
  output logic [63:0]               digest_word
);

  localparam int NW = BLOCK_BYTES / 4;

  logic [63:0] key_word [KEY_WORDS];
  logic [31:0] blk  [NW];
  logic [31:0] sw   [16];
  logic [31:0] hv   [8];
  logic [31:0] idig [8];
  logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
  logic [5:0]  fill;
  logic [5:0]  rnd;
  logic        busy;
  logic        add_phase;
  logic [63:0] bit_cnt;
  logic [7:0]  data_q;

  logic [31:0] w_cur, t1, t2;
  logic [63:0] len_val;
  logic [7:0]  wr_val;
  logic [7:0]  pad;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_WORDS; i++) key_word[i] <= '0;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(KEY_WORDS))) begin
      key_word[cfg_index[2:0]] <= cfg_data;
    end
  end

  // message byte held from the accepting edge
  always_ff @(posedge clk) begin
    if (cmd.cap_byte) data_q <= data_byte;
  end

  // schedule word and round terms
  always_comb begin
    if (rnd < 6'd16) begin
      w_cur = blk[rnd[3:0]];
    end else begin
      w_cur = sw[0] + ssig0(sw[1]) + sw[9] + ssig1(sw[14]);
    end
    t1 = vh + bsig1(ve) + ((ve & vf) ^ (~ve & vg)) + RND_K[rnd] + w_cur;
    t2 = bsig0(va) + ((va & vb) ^ (va & vc) ^ (vb & vc));
  end

  // byte to write into the block buffer
  always_comb begin
    len_val = cmd.len_outer ? OUTER_BITS : bit_cnt;
    pad     = cmd.pad_outer ? OPAD : IPAD;
    case (cmd.wr_sel)
      WR_DATA: wr_val = data_q;
      WR_MARK: wr_val = 8'h80;
      WR_ZERO: wr_val = 8'h00;
      WR_LEN:  wr_val = len_val[8*(7-fill[2:0]) +: 8];
      default: wr_val = 8'h00;
    endcase
  end

  // block buffer, fill count and bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      bit_cnt <= '0;
    end else begin
      if (cmd.load_key) begin
        for (int i = 0; i < NW; i++) begin
          blk[i] <= key_word[i/2][32*(1-(i%2)) +: 32] ^ {4{pad}};
        end
        fill <= '0;
      end else if (cmd.load_dig) begin
        for (int i = 0; i < 8; i++) blk[i] <= idig[i];
        fill <= 6'd32;
      end else if (cmd.wr_byte) begin
        blk[fill[5:2]][8*(3-fill[1:0]) +: 8] <= wr_val;
        fill <= fill + 6'd1;
      end
      if (cmd.cnt_init) begin
        bit_cnt <= 64'd512;
      end else if (cmd.cnt_add) begin
        bit_cnt <= bit_cnt + 64'd8;
      end
    end
  end

  // round unit: 64 rounds, then a fold into the hash state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      add_phase <= 1'b0;
      rnd       <= '0;
    end else if (cmd.start_comp) begin
      busy      <= 1'b1;
      add_phase <= 1'b0;
      rnd       <= '0;
    end else if (busy && add_phase) begin
      busy      <= 1'b0;
      add_phase <= 1'b0;
    end else if (busy) begin
      rnd <= rnd + 6'd1;
      if (rnd == 6'd63) add_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      for (int i = 0; i < 8; i++) hv[i] <= IV[i];
    end else if (busy && add_phase) begin
      hv[0] <= hv[0] + va; hv[1] <= hv[1] + vb;
      hv[2] <= hv[2] + vc; hv[3] <= hv[3] + vd;
      hv[4] <= hv[4] + ve; hv[5] <= hv[5] + vf;
      hv[6] <= hv[6] + vg; hv[7] <= hv[7] + vh;
    end
    if (cmd.save_dig) begin
      for (int i = 0; i < 8; i++) idig[i] <= hv[i];
    end
    if (cmd.start_comp) begin
      // a key block starts from the initial hash loaded in the same cycle
      if (cmd.load_key) begin
        va <= IV[0]; vb <= IV[1]; vc <= IV[2]; vd <= IV[3];
        ve <= IV[4]; vf <= IV[5]; vg <= IV[6]; vh <= IV[7];
      end else begin
        va <= hv[0]; vb <= hv[1]; vc <= hv[2]; vd <= hv[3];
        ve <= hv[4]; vf <= hv[5]; vg <= hv[6]; vh <= hv[7];
      end
    end else if (busy && !add_phase) begin
      vh <= vg; vg <= vf; vf <= ve; ve <= vd + t1;
      vd <= vc; vc <= vb; vb <= va; va <= t1 + t2;
      for (int i = 0; i < 15; i++) sw[i] <= sw[i+1];
      sw[15] <= w_cur;
    end
  end

  assign stat.busy   = busy;
  assign stat.fill   = fill;
  assign digest_word = {hv[{word_sel, 1'b0}], hv[{word_sel, 1'b1}]};

endmodule
`default_nettype wire

>>> src/hsha_ctrl.sv
// Controller: sequences key blocks, message bytes, padding, compressions and output.
`default_nettype none
module hsha_ctrl
  import hsha_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_fire,
  input  wire logic       has_byte,
  input  wire logic       last_byte,
  input  wire logic       out_fire,
  input  wire dp_stat_t   stat,
  output dp_cmd_t         cmd,
  output logic            in_ready,
  output logic            out_valid,
  output logic [1:0]      word_sel
);

  typedef enum logic [3:0] {
    S_IDLE, S_IKEY, S_BYTE, S_AFTER, S_MARK, S_ZERO, S_LEN,
    S_FIN, S_OKEY, S_ODIG, S_CWAIT, S_OUT
  } state_t;

  state_t     state, ret;
  logic       active, has_q, last_q, outer;
  logic [1:0] kidx;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign word_sel  = kidx;

  always_comb begin
    cmd           = '0;
    cmd.wr_sel    = WR_DATA;
    cmd.len_outer = outer;
    cmd.pad_outer = outer;
    case (state)
      S_IDLE:  cmd.cap_byte = in_fire;
      S_IKEY:  begin cmd.load_key = 1'b1; cmd.cnt_init = 1'b1; end
      S_BYTE:  begin
        cmd.wr_byte    = has_q;
        cmd.cnt_add    = has_q;
        cmd.start_comp = has_q && (stat.fill == 6'd63);
      end
      S_MARK:  begin
        cmd.wr_byte = 1'b1; cmd.wr_sel = WR_MARK;
        cmd.start_comp = (stat.fill == 6'd63);
      end
      S_ZERO:  if (stat.fill != 6'd56) begin
        cmd.wr_byte = 1'b1; cmd.wr_sel = WR_ZERO;
        cmd.start_comp = (stat.fill == 6'd63);
      end
      S_LEN:   begin
        cmd.wr_byte = 1'b1; cmd.wr_sel = WR_LEN;
        cmd.start_comp = (stat.fill == 6'd63);
      end
      S_FIN:   cmd.save_dig = !outer;
      S_OKEY:  begin cmd.load_key = 1'b1; cmd.pad_outer = 1'b1; end
      S_ODIG:  cmd.load_dig = 1'b1;
      default: ;
    endcase
    if (state == S_IKEY || state == S_OKEY) cmd.start_comp = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ret    <= S_IDLE;
      active <= 1'b0;
      outer  <= 1'b0;
      kidx   <= '0;
      has_q  <= 1'b0;
      last_q <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_fire) begin
          has_q  <= has_byte;
          last_q <= last_byte;
          if (has_byte || last_byte) state <= active ? S_BYTE : S_IKEY;
        end
        S_IKEY: begin
          active <= 1'b1;
          outer  <= 1'b0;
          ret    <= S_BYTE;
          state  <= S_CWAIT;
        end
        S_BYTE: begin
          ret   <= S_AFTER;
          state <= (has_q && stat.fill == 6'd63) ? S_CWAIT : S_AFTER;
        end
        S_AFTER: state <= last_q ? S_MARK : S_IDLE;
        S_MARK: begin
          ret   <= S_ZERO;
          state <= (stat.fill == 6'd63) ? S_CWAIT : S_ZERO;
        end
        S_ZERO: begin
          ret <= S_ZERO;
          if (stat.fill == 6'd56) state <= S_LEN;
          else if (stat.fill == 6'd63) state <= S_CWAIT;
        end
        S_LEN: if (stat.fill == 6'd63) begin
          ret   <= S_FIN;
          state <= S_CWAIT;
        end
        S_FIN: begin
          kidx  <= '0;
          state <= outer ? S_OUT : S_OKEY;
        end
        S_OKEY: begin
          ret   <= S_ODIG;
          state <= S_CWAIT;
        end
        S_ODIG: begin
          outer <= 1'b1;
          state <= S_MARK;
        end
        S_CWAIT: if (!stat.busy) state <= ret;
        S_OUT: if (out_fire) begin
          kidx <= kidx + 2'd1;
          if (kidx == 2'd3) begin
            active <= 1'b0;
            outer  <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
